// File: design/bb3_pkg.sv
// Shared constants, codes and controller/datapath interface types of the 3x3 box blur.
package bb3_pkg;

    // Frame geometry limits and derived widths.
    localparam int MAX_WIDTH    = 1024;
    localparam int ROWS_LIMIT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(ROWS_LIMIT);
    localparam int WEFF_W       = COL_W + 1;
    localparam int HEFF_W       = ROW_W + 1;

    // Pixel and channel widths.
    localparam int CHAN_W       = 8;
    localparam int NUM_CHAN     = 3;
    localparam int PIX_W        = CHAN_W * NUM_CHAN;
    localparam int CHAN_MAX     = 255;

    // Configuration registers.
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    // Input command codes carried in tuser.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Line buffer read address source.
    typedef enum logic [1:0] {
        RD_COLUMN     = 2'd0,
        RD_DRAIN_PREV = 2'd1,
        RD_DRAIN_CUR  = 2'd2,
        RD_DRAIN_NEXT = 2'd3
    } rd_sel_t;

    // Window columns used by the summation: the full window, or the right-edge
    // view where the newest column is the center and nothing lies to the right.
    typedef enum logic {
        MODE_FULL = 1'b0,
        MODE_EDGE = 1'b1
    } sum_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;
        rd_sel_t   rd_sel;
        logic      shift;
        logic      pixel_step;
        logic      drain_step;
        logic      sum;
        sum_mode_t sum_mode;
        logic      divide;
        logic      load;
        logic      last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic draining;
        logic emit_full;
        logic emit_edge;
        logic out_free;
    } dp_stat_t;

endpackage

// File: design/box_blur_3x3_rgb_top.sv
// Top level of the streaming 3x3 RGB box blur: controller and datapath.
//
//  Channel   Direction  Transaction                 Payload
//  s_axis    in         tvalid & tready             tdata: red, green, blue; tuser: command
//  m_axis    out        tvalid & tready             tdata: red, green, blue; tlast; tuser
//  cfg       in         cfg_write                   cfg_index, cfg_data
//
// A pixel passes through the registered line buffer read and the window shift; each result
// it causes then adds the sum, reciprocal multiply and correction steps. A drain command
// reads three line buffer columns before its single result.
// Reset clears the raster counters and the drain flag; the line buffers need no clearing.
// A result stalled at the output holds the block after its divide step; the next
// item is accepted as soon as the previous result has been loaded into the output register.
module box_blur_3x3_rgb_top
    import bb3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic                   s_axis_tuser,   // command
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [PIX_W-1:0]       m_axis_tdata,   // blur_red, blur_green, blur_blue
    output logic                   m_axis_tlast,   // run_last
    output logic                   m_axis_tuser,   // frame_done
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer.
    bb3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Line buffers, window and arithmetic.
    bb3_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_done  (m_axis_tuser)
    );

endmodule

// File: design/bb3_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bb3_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/bb3_ctrl.sv
// Controller state machine that sequences line buffer access, summing and rounding.
module bb3_ctrl
    import bb3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_cmd,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_PX_RD  = 10'b0000000010,
        S_PX_SH  = 10'b0000000100,
        S_DR_RD0 = 10'b0000001000,
        S_DR_RD1 = 10'b0000010000,
        S_DR_RD2 = 10'b0000100000,
        S_DR_SH  = 10'b0001000000,
        S_SUM    = 10'b0010000000,
        S_DIV    = 10'b0100000000,
        S_LOAD   = 10'b1000000000
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    sum_mode_t mode_reg;
    sum_mode_t mode_next;
    logic      pend_edge_reg;
    logic      pend_edge_next;
    logic      in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        pend_edge_next = pend_edge_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_COLUMN;
        cmd.sum_mode   = mode_reg;
        cmd.capture    = in_fire;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd == CMD_PIXEL && !stat.draining)
                    begin
                        state_next = S_PX_RD;
                    end
                    else if (in_cmd == CMD_DRAIN && stat.draining)
                    begin
                        state_next = S_DR_RD0;
                    end
                end
            end
            S_PX_RD:
            begin
                cmd.rd_sel = RD_COLUMN;
                state_next = S_PX_SH;
            end
            S_PX_SH:
            begin
                cmd.shift      = 1'b1;
                cmd.pixel_step = 1'b1;
                if (stat.emit_full)
                begin
                    mode_next      = MODE_FULL;
                    pend_edge_next = stat.emit_edge;
                    state_next     = S_SUM;
                end
                else if (stat.emit_edge)
                begin
                    mode_next      = MODE_EDGE;
                    pend_edge_next = 1'b0;
                    state_next     = S_SUM;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DR_RD0:
            begin
                cmd.rd_sel = RD_DRAIN_PREV;
                state_next = S_DR_RD1;
            end
            S_DR_RD1:
            begin
                cmd.rd_sel = RD_DRAIN_CUR;
                cmd.shift  = 1'b1;
                state_next = S_DR_RD2;
            end
            S_DR_RD2:
            begin
                cmd.rd_sel = RD_DRAIN_NEXT;
                cmd.shift  = 1'b1;
                state_next = S_DR_SH;
            end
            S_DR_SH:
            begin
                cmd.shift      = 1'b1;
                cmd.drain_step = 1'b1;
                mode_next      = MODE_FULL;
                pend_edge_next = 1'b0;
                state_next     = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.divide = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.last = !pend_edge_reg;
                    if (pend_edge_reg)
                    begin
                        mode_next      = MODE_EDGE;
                        pend_edge_next = 1'b0;
                        state_next     = S_SUM;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_FULL;
            pend_edge_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            pend_edge_reg <= pend_edge_next;
        end
    end

    // An accepted pixel outside the drain phase always starts a line buffer read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_cmd == CMD_PIXEL && !stat.draining) |=> state_reg == S_PX_RD)
    else $error("accepted pixel did not start a line buffer read");

    // A blocked result holds the controller in the load state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && !stat.out_free) |=> state_reg == S_LOAD)
    else $error("controller left the load state while the output was blocked");

    // A pending right-edge result only follows a full-window result.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_edge_reg |-> mode_reg == MODE_FULL)
    else $error("pending edge result without a full-window result first");

endmodule

// File: design/bb3_datapath.sv
// Datapath: configuration, counters, line buffers, 3x3 window, summing, rounding divide, output.
module bb3_datapath
    import bb3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [PIX_W-1:0]       in_data,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [PIX_W-1:0]       out_data,
    output logic                   out_last,
    output logic                   out_done
);

    localparam int SUM_W       = $clog2(9 * CHAN_MAX + 1);
    localparam int RECIP_W     = 11;
    localparam int RECIP_SHIFT = 12;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int FIX_W       = SUM_W + 4;
    localparam logic [RECIP_W-1:0] RECIP_3 = 11'd1365;
    localparam logic [RECIP_W-1:0] RECIP_9 = 11'd455;

    typedef enum logic [1:0] {
        DIV_1 = 2'd0,
        DIV_3 = 2'd1,
        DIV_9 = 2'd2
    } div_sel_t;

    // Configuration and frame position.
    logic [WIDTH_REG_W-1:0]  width_cfg_reg;
    logic [HEIGHT_REG_W-1:0] height_cfg_reg;
    logic [COL_W-1:0]        column_count_reg;
    logic [ROW_W-1:0]        row_count_reg;
    logic [COL_W-1:0]        drain_column_reg;
    logic                    draining_reg;
    logic [WEFF_W-1:0]       width_eff;
    logic [HEFF_W-1:0]       height_eff;
    logic                    row_end;
    logic                    last_row;
    logic                    drain_left;
    logic                    drain_right;
    logic                    drain_done;

    // Line buffers and window.
    logic [COL_W-1:0]        raddr;
    logic [PIX_W-1:0]        upper_rd;
    logic [PIX_W-1:0]        middle_rd;
    logic [PIX_W-1:0]        px_reg;
    logic [PIX_W-1:0]        win_reg [3][3];

    // Neighborhood context latched with the window.
    logic                    ctx_top_reg;
    logic                    ctx_bot_reg;
    logic                    ctx_left_reg;
    logic                    ctx_right_reg;
    logic                    ctx_left_edge_reg;
    logic                    ctx_done_reg;

    // Arithmetic stages.
    logic [2:0]              row_en;
    logic [2:0]              col_en;
    logic [1:0]              rows_n;
    logic [1:0]              cols_n;
    logic [3:0]              n_comb;
    logic [SUM_W-1:0]        sum_comb [NUM_CHAN];
    logic [SUM_W-1:0]        sum_reg  [NUM_CHAN];
    logic [3:0]              n_reg;
    logic [1:0]              div_shift;
    div_sel_t                dsel_comb;
    div_sel_t                dsel_reg;
    logic [RECIP_W-1:0]      recip;
    logic [SUM_W-1:0]        t_comb   [NUM_CHAN];
    logic [SUM_W-1:0]        ts_comb  [NUM_CHAN];
    logic [PROD_W-1:0]       prod     [NUM_CHAN];
    logic [SUM_W-1:0]        q0_comb  [NUM_CHAN];
    logic [SUM_W-1:0]        ts_reg   [NUM_CHAN];
    logic [SUM_W-1:0]        q0_reg   [NUM_CHAN];
    logic [FIX_W-1:0]        dq       [NUM_CHAN];
    logic [FIX_W-1:0]        rem      [NUM_CHAN];
    logic [FIX_W-1:0]        dval;
    logic [SUM_W-1:0]        qf       [NUM_CHAN];
    logic [PIX_W-1:0]        res_comb;

    // Output register.
    logic                    out_valid_reg;
    logic [PIX_W-1:0]        out_data_reg;
    logic                    out_last_reg;
    logic                    out_done_reg;

    // Effective frame size: zero acts as one, large values saturate.
    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            width_eff = WEFF_W'(1);
        end
        else if (int'(width_cfg_reg) > MAX_WIDTH)
        begin
            width_eff = WEFF_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WEFF_W'(width_cfg_reg);
        end
        if (height_cfg_reg == '0)
        begin
            height_eff = HEFF_W'(1);
        end
        else if (int'(height_cfg_reg) > ROWS_LIMIT)
        begin
            height_eff = HEFF_W'(ROWS_LIMIT);
        end
        else
        begin
            height_eff = HEFF_W'(height_cfg_reg);
        end
    end

    // Row and column end detection and drain neighborhood.
    assign row_end     = {1'b0, column_count_reg} >= width_eff - WEFF_W'(1);
    assign last_row    = {1'b0, row_count_reg} >= height_eff - HEFF_W'(1);
    assign drain_left  = drain_column_reg != '0;
    assign drain_right = ({1'b0, drain_column_reg} + WEFF_W'(1)) < width_eff;
    assign drain_done  = {1'b0, drain_column_reg} >= width_eff - WEFF_W'(1);

    // Status toward the controller.
    always_comb
    begin
        stat.draining  = draining_reg;
        stat.emit_full = (row_count_reg != '0) && (column_count_reg != '0);
        stat.emit_edge = (row_count_reg != '0) && row_end;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default:          width_cfg_reg  <= width_cfg_reg;
            endcase
        end
    end

    // Raster position and drain counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            drain_column_reg <= '0;
            draining_reg     <= 1'b0;
        end
        else if (cmd.pixel_step)
        begin
            if (row_end)
            begin
                column_count_reg <= '0;
                if (last_row)
                begin
                    row_count_reg    <= '0;
                    draining_reg     <= 1'b1;
                    drain_column_reg <= '0;
                end
                else
                begin
                    row_count_reg <= row_count_reg + ROW_W'(1);
                end
            end
            else
            begin
                column_count_reg <= column_count_reg + COL_W'(1);
            end
        end
        else if (cmd.drain_step)
        begin
            if (drain_done)
            begin
                draining_reg     <= 1'b0;
                drain_column_reg <= '0;
            end
            else
            begin
                drain_column_reg <= drain_column_reg + COL_W'(1);
            end
        end
    end

    // Line buffer read address.
    always_comb
    begin
        case (cmd.rd_sel)
            RD_COLUMN:     raddr = column_count_reg;
            RD_DRAIN_PREV: raddr = drain_column_reg - COL_W'(1);
            RD_DRAIN_CUR:  raddr = drain_column_reg;
            RD_DRAIN_NEXT: raddr = drain_column_reg + COL_W'(1);
            default:       raddr = column_count_reg;
        endcase
    end

    // Two rows of history: the upper row takes the old middle entry.
    bb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (cmd.pixel_step),
        .waddr (column_count_reg),
        .wdata (middle_rd),
        .raddr (raddr),
        .rdata (upper_rd)
    );

    bb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (cmd.pixel_step),
        .waddr (column_count_reg),
        .wdata (px_reg),
        .raddr (raddr),
        .rdata (middle_rd)
    );

    // Pixel capture, window shift and neighborhood context.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg <= in_data;
        end
        if (cmd.shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= upper_rd;
            win_reg[1][2] <= middle_rd;
            win_reg[2][2] <= cmd.pixel_step ? px_reg : '0;
        end
        if (cmd.pixel_step)
        begin
            ctx_top_reg       <= row_count_reg >= ROW_W'(2);
            ctx_bot_reg       <= 1'b1;
            ctx_left_reg      <= column_count_reg >= COL_W'(2);
            ctx_right_reg     <= 1'b1;
            ctx_left_edge_reg <= column_count_reg != '0;
            ctx_done_reg      <= 1'b0;
        end
        else if (cmd.drain_step)
        begin
            ctx_top_reg       <= height_eff >= HEFF_W'(2);
            ctx_bot_reg       <= 1'b0;
            ctx_left_reg      <= drain_left;
            ctx_right_reg     <= drain_right;
            ctx_left_edge_reg <= 1'b0;
            ctx_done_reg      <= drain_done;
        end
    end

    // Masked window sum per channel and count of pixels inside the image.
    always_comb
    begin
        row_en = {ctx_bot_reg, 1'b1, ctx_top_reg};
        if (cmd.sum_mode == MODE_EDGE)
        begin
            col_en = {1'b1, ctx_left_edge_reg, 1'b0};
        end
        else
        begin
            col_en = {ctx_right_reg, 1'b1, ctx_left_reg};
        end
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            sum_comb[ch] = '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (row_en[i] && col_en[j])
                    begin
                        sum_comb[ch] = sum_comb[ch]
                                     + SUM_W'(win_reg[i][j][ch*CHAN_W +: CHAN_W]);
                    end
                end
            end
        end
        rows_n = 2'(row_en[0]) + 2'(row_en[1]) + 2'(row_en[2]);
        cols_n = 2'(col_en[0]) + 2'(col_en[1]) + 2'(col_en[2]);
        n_comb = 4'(rows_n) * 4'(cols_n);
    end

    // Rounding divide, first half: add n/2, split n into a shift and 1, 3 or 9,
    // then multiply by a reciprocal that may land one below the true quotient.
    always_comb
    begin
        case (n_reg)
            4'd1:
            begin
                div_shift = 2'd0;
                dsel_comb = DIV_1;
            end
            4'd2:
            begin
                div_shift = 2'd1;
                dsel_comb = DIV_1;
            end
            4'd3:
            begin
                div_shift = 2'd0;
                dsel_comb = DIV_3;
            end
            4'd4:
            begin
                div_shift = 2'd2;
                dsel_comb = DIV_1;
            end
            4'd6:
            begin
                div_shift = 2'd1;
                dsel_comb = DIV_3;
            end
            4'd9:
            begin
                div_shift = 2'd0;
                dsel_comb = DIV_9;
            end
            default:
            begin
                div_shift = 2'd0;
                dsel_comb = DIV_1;
            end
        endcase
        recip = (dsel_comb == DIV_9) ? RECIP_9 : RECIP_3;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            t_comb[ch]  = sum_reg[ch] + SUM_W'(n_reg >> 1);
            ts_comb[ch] = t_comb[ch] >> div_shift;
            prod[ch]    = PROD_W'(ts_comb[ch]) * PROD_W'(recip);
            if (dsel_comb == DIV_1)
            begin
                q0_comb[ch] = ts_comb[ch];
            end
            else
            begin
                q0_comb[ch] = SUM_W'(prod[ch] >> RECIP_SHIFT);
            end
        end
    end

    // Rounding divide, second half: one compare and add corrects the estimate.
    always_comb
    begin
        case (dsel_reg)
            DIV_3:   dval = FIX_W'(3);
            DIV_9:   dval = FIX_W'(9);
            default: dval = FIX_W'(1);
        endcase
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            case (dsel_reg)
                DIV_3:   dq[ch] = (FIX_W'(q0_reg[ch]) << 1) + FIX_W'(q0_reg[ch]);
                DIV_9:   dq[ch] = (FIX_W'(q0_reg[ch]) << 3) + FIX_W'(q0_reg[ch]);
                default: dq[ch] = FIX_W'(q0_reg[ch]);
            endcase
            rem[ch] = FIX_W'(ts_reg[ch]) - dq[ch];
            qf[ch]  = (rem[ch] >= dval) ? q0_reg[ch] + SUM_W'(1) : q0_reg[ch];
            if (qf[ch] > SUM_W'(CHAN_MAX))
            begin
                res_comb[ch*CHAN_W +: CHAN_W] = CHAN_W'(CHAN_MAX);
            end
            else
            begin
                res_comb[ch*CHAN_W +: CHAN_W] = qf[ch][CHAN_W-1:0];
            end
        end
    end

    // Arithmetic stage registers.
    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sum_reg <= sum_comb;
            n_reg   <= n_comb;
        end
        if (cmd.divide)
        begin
            ts_reg   <= ts_comb;
            q0_reg   <= q0_comb;
            dsel_reg <= dsel_comb;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= res_comb;
            out_last_reg <= cmd.last;
            out_done_reg <= ctx_done_reg;
        end
    end

    // Output valid: set on load, cleared when the transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

    // The drain phase starts from the top-left corner of the next frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> (column_count_reg == '0 && row_count_reg == '0))
    else $error("raster position not at frame start while draining");

    // The drain column only moves while draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        (drain_column_reg != '0) |-> draining_reg)
    else $error("drain column advanced outside the drain phase");

    // A new result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
    else $error("output register loaded while holding an untaken result");

endmodule
